// ===== src/h264fu_pkg.sv =====
`timescale 1ns / 1ps

package h264fu_pkg;

  localparam logic [7:0]  FU_A_TYPE   = 8'd28;
  localparam logic [7:0]  NRI_MASK    = 8'h60;
  localparam logic [7:0]  TYPE_MASK   = 8'h1F;
  localparam logic [7:0]  FU_START    = 8'h80;
  localparam logic [7:0]  FU_END      = 8'h40;
  localparam logic [15:0] LIMIT_RESET = 16'd1400;
  localparam logic [15:0] FU_OVERHEAD = 16'd2;

  // one queued payload byte, optionally preceded by the two FU-A header words
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic        has_fu;
    logic        first;
    logic        last;
    logic        mark;
    logic [31:0] ts;
  } q_entry_t;

  // back-end word sequencer
  typedef enum logic [1:0] {
    ST_LEAD,
    ST_HDR,
    ST_DATA
  } emit_st_t;

endpackage

// ===== src/h264_fu_a_packetizer.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid/in_ready    data_byte, nal_start, nal_end, nal_length, recv_time
// out      out_valid/out_ready  pkt_byte, pkt_first, pkt_last, marker, timestamp
// cfg      cfg_wr_en            cfg_wr_data = packet_limit
//
// One input word per cycle while the queue has room; a fragment's opening byte
// expands into three output words: indicator, FU header, then the data byte.
// The front classifies each byte as it is accepted; the queue (QUEUE_DEPTH entries)
// absorbs header expansion, and in_ready drops only when the queue is full.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// in_ready never depends on out_ready combinationally.
module h264_fu_a_packetizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // NAL byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_nal_start,
  input  logic        in_nal_end,
  input  logic [15:0] in_nal_length,
  input  logic [63:0] in_recv_time,
  // RTP payload stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pkt_byte,
  output logic        out_pkt_first,
  output logic        out_pkt_last,
  output logic        out_marker,
  output logic [31:0] out_timestamp
);

  logic                 in_fire;
  logic                 push;
  logic                 pop;
  logic                 full;
  logic                 empty;
  logic                 nal_end_seen;
  h264fu_pkg::q_entry_t push_entry;
  h264fu_pkg::q_entry_t head;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;
  // NAL length alone decides where a unit ends; the end mark is advisory
  assign nal_end_seen = in_fire && in_nal_end;

  // classify bytes, track NAL / fragment counters and timestamp base
  h264fu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_fire       (in_fire),
    .in_data_byte  (in_data_byte),
    .in_nal_start  (in_nal_start),
    .in_nal_length (in_nal_length),
    .in_recv_time  (in_recv_time),
    .push          (push),
    .push_entry    (push_entry)
  );

  // decouples byte intake from word emission
  h264fu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  // expand entries into indicator / FU header / data words
  h264fu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pkt_byte  (out_pkt_byte),
    .out_pkt_first (out_pkt_first),
    .out_pkt_last  (out_pkt_last),
    .out_marker    (out_marker),
    .out_timestamp (out_timestamp)
  );

`ifndef SYNTH
  a_end_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    nal_end_seen |-> in_ready)
    else $error("end mark seen without acceptance");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pkt_byte)))
    else $error("output word changed under stall");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> in_fire)
    else $error("queue write without accepted input");
`endif

endmodule

// ===== src/h264fu_front.sv =====
`timescale 1ns / 1ps

module h264fu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 in_fire,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_nal_start,
  input  logic [15:0]          in_nal_length,
  input  logic [63:0]          in_recv_time,
  output logic                 push,
  output h264fu_pkg::q_entry_t push_entry
);

  logic [15:0] limit_r, limit_nxt;
  logic [15:0] psize_r, psize_nxt;     // fragment payload size, kept ready
  logic [31:0] base_lo_r, base_lo_nxt;
  logic        base_set_r, base_set_nxt;
  logic [31:0] cur_ts_r, cur_ts_nxt;
  logic        frag_r, frag_nxt;
  logic [7:0]  saved_hdr_r, saved_hdr_nxt;
  logic [15:0] left_nal_r, left_nal_nxt;
  logic [15:0] left_pkt_r, left_pkt_nxt;
  logic        first_frag_r, first_frag_nxt;

  logic [15:0] len_eff;
  logic [31:0] ts_new;
  logic        endf;
  logic [15:0] chunk;

  assign len_eff = (in_nal_length == '0) ? 16'd1 : in_nal_length;
  assign ts_new  = base_set_r ? (in_recv_time[31:0] - base_lo_r) : '0;
  assign endf    = (left_nal_r <= psize_r);
  assign chunk   = endf ? left_nal_r : psize_r;

  always_comb begin
    limit_nxt      = limit_r;
    psize_nxt      = psize_r;
    base_lo_nxt    = base_lo_r;
    base_set_nxt   = base_set_r;
    cur_ts_nxt     = cur_ts_r;
    frag_nxt       = frag_r;
    saved_hdr_nxt  = saved_hdr_r;
    left_nal_nxt   = left_nal_r;
    left_pkt_nxt   = left_pkt_r;
    first_frag_nxt = first_frag_r;
    push           = 1'b0;
    push_entry     = '0;
    push_entry.data = in_data_byte;
    push_entry.ts   = cur_ts_r;

    if (cfg_wr_en) begin
      limit_nxt = cfg_wr_data;
      psize_nxt = (cfg_wr_data > (h264fu_pkg::FU_OVERHEAD + 16'd1)) ?
                  (cfg_wr_data - h264fu_pkg::FU_OVERHEAD) : 16'd1;
    end

    if (in_fire) begin
      if (in_nal_start) begin
        if (!base_set_r) begin
          base_lo_nxt  = in_recv_time[31:0];
          base_set_nxt = |in_recv_time;
        end
        cur_ts_nxt     = ts_new;
        saved_hdr_nxt  = in_data_byte;
        left_pkt_nxt   = '0;
        first_frag_nxt = 1'b1;
        frag_nxt       = !(len_eff < limit_r);
        left_nal_nxt   = len_eff - 16'd1;
        if (len_eff < limit_r) begin
          push             = 1'b1;
          push_entry.first = 1'b1;
          push_entry.last  = (len_eff == 16'd1);
          push_entry.mark  = 1'b1;
          push_entry.ts    = ts_new;
        end
      end else if (left_nal_r != '0) begin
        push         = 1'b1;
        left_nal_nxt = left_nal_r - 16'd1;
        if (!frag_r) begin
          push_entry.last = (left_nal_r == 16'd1);
          push_entry.mark = 1'b1;
        end else if (left_pkt_r == '0) begin
          // opening byte of a fragment: indicator and FU header go first
          push_entry.has_fu = 1'b1;
          push_entry.fu_ind = (saved_hdr_r & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
          push_entry.fu_hdr = (first_frag_r ? h264fu_pkg::FU_START : 8'h00) |
                              (endf ? h264fu_pkg::FU_END : 8'h00) |
                              (saved_hdr_r & h264fu_pkg::TYPE_MASK);
          push_entry.last   = (chunk == 16'd1);
          push_entry.mark   = endf;
          first_frag_nxt    = 1'b0;
          left_pkt_nxt      = chunk - 16'd1;
        end else begin
          push_entry.last = (left_pkt_r == 16'd1);
          push_entry.mark = (left_pkt_r == left_nal_r);
          left_pkt_nxt    = left_pkt_r - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= h264fu_pkg::LIMIT_RESET;
      psize_r      <= h264fu_pkg::LIMIT_RESET - h264fu_pkg::FU_OVERHEAD;
      base_lo_r    <= '0;
      base_set_r   <= 1'b0;
      cur_ts_r     <= '0;
      frag_r       <= 1'b0;
      saved_hdr_r  <= '0;
      left_nal_r   <= '0;
      left_pkt_r   <= '0;
      first_frag_r <= 1'b1;
    end else begin
      limit_r      <= limit_nxt;
      psize_r      <= psize_nxt;
      base_lo_r    <= base_lo_nxt;
      base_set_r   <= base_set_nxt;
      cur_ts_r     <= cur_ts_nxt;
      frag_r       <= frag_nxt;
      saved_hdr_r  <= saved_hdr_nxt;
      left_nal_r   <= left_nal_nxt;
      left_pkt_r   <= left_pkt_nxt;
      first_frag_r <= first_frag_nxt;
    end
  end

endmodule

// ===== src/h264fu_queue.sv =====
`timescale 1ns / 1ps

module h264fu_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  h264fu_pkg::q_entry_t push_entry,
  input  logic                 pop,
  output logic                 full,
  output logic                 empty,
  output h264fu_pkg::q_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  h264fu_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue pop while empty");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("queue count did not track push");
`endif

endmodule

// ===== src/h264fu_back.sv =====
`timescale 1ns / 1ps

module h264fu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  h264fu_pkg::q_entry_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_pkt_byte,
  output logic                 out_pkt_first,
  output logic                 out_pkt_last,
  output logic                 out_marker,
  output logic [31:0]          out_timestamp
);

  h264fu_pkg::emit_st_t st_r, st_nxt;
  logic fire;

  assign out_valid = !empty;
  assign fire      = out_valid && out_ready;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      h264fu_pkg::ST_LEAD: begin
        if (fire && head.has_fu) begin
          st_nxt = h264fu_pkg::ST_HDR;
        end
      end
      h264fu_pkg::ST_HDR: begin
        if (fire) begin
          st_nxt = h264fu_pkg::ST_DATA;
        end
      end
      h264fu_pkg::ST_DATA: begin
        if (fire) begin
          st_nxt = h264fu_pkg::ST_LEAD;
        end
      end
      default: st_nxt = h264fu_pkg::ST_LEAD;
    endcase
  end

  always_comb begin
    out_timestamp = head.ts;
    out_marker    = head.mark;
    out_pkt_byte  = head.data;
    out_pkt_first = head.first;
    out_pkt_last  = head.last;
    pop           = 1'b0;
    case (st_r)
      h264fu_pkg::ST_LEAD: begin
        if (head.has_fu) begin
          out_pkt_byte  = head.fu_ind;
          out_pkt_first = 1'b1;
          out_pkt_last  = 1'b0;
        end else begin
          pop = fire;
        end
      end
      h264fu_pkg::ST_HDR: begin
        out_pkt_byte  = head.fu_hdr;
        out_pkt_first = 1'b0;
        out_pkt_last  = 1'b0;
      end
      h264fu_pkg::ST_DATA: begin
        pop = fire;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= h264fu_pkg::ST_LEAD;
    end else begin
      st_r <= st_nxt;
    end
  end

`ifndef SYNTH
  a_hdr_only_fu: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != h264fu_pkg::ST_LEAD) |-> (!empty && head.has_fu))
    else $error("header phase without FU-A entry");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (st_r == $past(st_r)))
    else $error("sequencer moved during stall");

  a_pop_last_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fire && (st_r == h264fu_pkg::ST_DATA || !head.has_fu)))
    else $error("entry popped before its data word");
`endif

endmodule
